// ===== rtl/lddl_pkg.sv =====
`timescale 1ns / 1ps

package lddl_pkg;

   // Pool geometry
   localparam int NUM_CELLS = 256;
   localparam int IDX_W     = 8;
   localparam int CNT_W     = 9;

   localparam logic [CNT_W-1:0] CELL_LIMIT = CNT_W'(NUM_CELLS);
   localparam logic [IDX_W-1:0] LAST_CELL  = IDX_W'(NUM_CELLS - 1);

   // Action codes on req_action
   localparam logic [2:0] ACT_POP_HEAD  = 3'd0;
   localparam logic [2:0] ACT_POP_TAIL  = 3'd1;
   localparam logic [2:0] ACT_UNLINK    = 3'd2;
   localparam logic [2:0] ACT_PUSH_HEAD = 3'd3;
   localparam logic [2:0] ACT_PUSH_TAIL = 3'd4;
   localparam logic [2:0] ACT_INSERT    = 3'd5;
   localparam logic [2:0] ACT_READ      = 3'd6;
   localparam logic [2:0] ACT_CLEAR     = 3'd7;

   // Link or pointer: cell index with a valid bit
   typedef struct packed {
      logic             v;
      logic [IDX_W-1:0] idx;
   } link_type;

   localparam link_type LINK_NONE = '0;

   // Classified operation handed from front to back
   typedef enum logic [3:0] {
      OP_NOP,
      OP_POP_HEAD,
      OP_POP_TAIL,
      OP_UNLINK,
      OP_PUSH_HEAD,
      OP_PUSH_TAIL,
      OP_INSERT,
      OP_READ,
      OP_CLEAR
   } op_type;

   typedef struct packed {
      op_type           op;
      logic [IDX_W-1:0] cell_idx;
      logic [IDX_W-1:0] after;
   } cmd_type;

   // Write requests to both link memories in one cycle
   typedef struct packed {
      logic             next_en;
      logic [IDX_W-1:0] next_addr;
      link_type         next_data;
      logic             prev_en;
      logic [IDX_W-1:0] prev_addr;
      link_type         prev_data;
   } wr_type;

   typedef struct packed {
      logic             status;
      logic             cell_valid;
      logic [IDX_W-1:0] result_cell;
      logic             prev_valid;
      logic [IDX_W-1:0] prev_index;
      logic             next_valid;
      logic [IDX_W-1:0] next_index;
      logic             head_valid;
      logic [IDX_W-1:0] head_index;
      logic             tail_valid;
      logic [IDX_W-1:0] tail_index;
      logic [CNT_W-1:0] count;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LINK,
      ST_WR2,
      ST_CLR_RD,
      ST_CLR_WR,
      ST_CLR_FIX
   } eng_state_type;

   function automatic link_type mk_link(input logic [IDX_W-1:0] i);
      link_type r;
      r.v   = 1'b1;
      r.idx = i;
      return r;
   endfunction

   // Power-on chain: cell i points on to i+1 and back to i-1
   function automatic link_type reset_next_link(input logic [IDX_W-1:0] i);
      link_type r;
      r.v   = (i != LAST_CELL);
      r.idx = r.v ? i + 1'b1 : '0;
      return r;
   endfunction

   function automatic link_type reset_prev_link(input logic [IDX_W-1:0] i);
      link_type r;
      r.v   = (i != '0);
      r.idx = r.v ? i - 1'b1 : '0;
      return r;
   endfunction

   // Build a result word; an index without its valid bit reads as zero
   function automatic rsp_type make_rsp(input logic status, input link_type res,
                                        input link_type rp, input link_type rn,
                                        input link_type hd, input link_type tl,
                                        input logic [CNT_W-1:0] cnt);
      rsp_type r;
      r.status      = status;
      r.cell_valid  = res.v;
      r.result_cell = res.v ? res.idx : '0;
      r.prev_valid  = rp.v;
      r.prev_index  = rp.v ? rp.idx : '0;
      r.next_valid  = rn.v;
      r.next_index  = rn.v ? rn.idx : '0;
      r.head_valid  = hd.v;
      r.head_index  = hd.v ? hd.idx : '0;
      r.tail_valid  = tl.v;
      r.tail_index  = tl.v ? tl.idx : '0;
      r.count       = cnt;
      return r;
   endfunction

endpackage

// ===== rtl/lddl_link_ram.sv =====
`timescale 1ns / 1ps

module lddl_link_ram
   import lddl_pkg::*;
#(
   parameter bit IS_NEXT = 1'b1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             wr_en,
   input  logic [IDX_W-1:0] wr_addr,
   input  link_type         wr_data,
   input  logic [IDX_W-1:0] rd_addr,
   output link_type         rd_data
);

   link_type               mem_ff [NUM_CELLS];
   logic [NUM_CELLS-1:0]   written_ff;
   link_type               rd_data_ff;
   logic                   rd_hit_ff;
   logic [IDX_W-1:0]       rd_addr_ff;

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
      rd_addr_ff <= rd_addr;
   end

   // Track entries written since reset; others hold the power-on chain
   always_ff @(posedge clock) begin
      if (reset) begin
         written_ff <= '0;
         rd_hit_ff  <= 1'b0;
      end else begin
         if (wr_en) begin
            written_ff[wr_addr] <= 1'b1;
         end
         rd_hit_ff <= written_ff[rd_addr];
      end
   end

   always_comb begin
      if (rd_hit_ff) begin
         rd_data = rd_data_ff;
      end else if (IS_NEXT) begin
         rd_data = reset_next_link(rd_addr_ff);
      end else begin
         rd_data = reset_prev_link(rd_addr_ff);
      end
   end

endmodule

// ===== rtl/lddl_front.sv =====
`timescale 1ns / 1ps

module lddl_front
   import lddl_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  logic [2:0]       req_action,
   input  logic [IDX_W-1:0] req_cell_req,
   input  logic [IDX_W-1:0] req_after_cell,
   output cmd_type          cmd,
   output logic             cmd_valid,
   input  logic             cmd_pop
);

   cmd_type    q_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] fill_ff, fill_in;
   cmd_type    cls;
   logic       c_ok, a_ok, push, pop;

   // Classify the word: range checks fold into a no-op
   always_comb begin
      c_ok         = ({1'b0, req_cell_req} < CELL_LIMIT);
      a_ok         = ({1'b0, req_after_cell} < CELL_LIMIT);
      cls.cell_idx = req_cell_req;
      cls.after    = req_after_cell;
      unique case (req_action)
         ACT_POP_HEAD:  cls.op = OP_POP_HEAD;
         ACT_POP_TAIL:  cls.op = OP_POP_TAIL;
         ACT_UNLINK:    cls.op = c_ok ? OP_UNLINK : OP_NOP;
         ACT_PUSH_HEAD: cls.op = c_ok ? OP_PUSH_HEAD : OP_NOP;
         ACT_PUSH_TAIL: cls.op = c_ok ? OP_PUSH_TAIL : OP_NOP;
         ACT_INSERT:    cls.op = (c_ok && a_ok) ? OP_INSERT : OP_NOP;
         ACT_READ:      cls.op = c_ok ? OP_READ : OP_NOP;
         ACT_CLEAR:     cls.op = OP_CLEAR;
      endcase
   end

   // Two-entry queue toward the back end
   assign busy      = (fill_ff == 2'd2);
   assign cmd_valid = (fill_ff != 2'd0);
   assign cmd       = q_ff[rd_ptr_ff];
   assign push      = start && !busy;
   assign pop       = cmd_pop && cmd_valid;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      fill_in   = fill_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= cls;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

endmodule

// ===== rtl/lddl_engine.sv =====
`timescale 1ns / 1ps

module lddl_engine
   import lddl_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  cmd_type cmd,
   input  logic    cmd_valid,
   output logic    cmd_pop,
   output rsp_type rsp,
   output logic    rsp_strobe
);

   eng_state_type    state_ff, state_in;
   cmd_type          cmd_ff, cmd_in;
   link_type         head_ff, head_in;
   link_type         tail_ff, tail_in;
   logic [CNT_W-1:0] count_ff, count_in;
   link_type         res_ff, res_in;
   link_type         rp_ff, rp_in;
   link_type         rn_ff, rn_in;
   logic             status_ff, status_in;
   logic             popped_ff, popped_in;
   wr_type           wr2_ff, wr2_in;
   rsp_type          rsp_ff, rsp_in;
   logic             strobe_ff, strobe_in;

   wr_type           wr;
   logic [IDX_W-1:0] next_raddr, prev_raddr;
   link_type         rn, rp;

   lddl_link_ram #(.IS_NEXT(1'b1)) u_next_ram (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (wr.next_en),
      .wr_addr (wr.next_addr),
      .wr_data (wr.next_data),
      .rd_addr (next_raddr),
      .rd_data (rn)
   );

   lddl_link_ram #(.IS_NEXT(1'b0)) u_prev_ram (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (wr.prev_en),
      .wr_addr (wr.prev_addr),
      .wr_data (wr.prev_data),
      .rd_addr (prev_raddr),
      .rd_data (rp)
   );

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               if (cmd.op == OP_CLEAR) begin
                  state_in = (count_ff != '0 && head_ff.v) ? ST_CLR_WR : ST_CLR_FIX;
               end else begin
                  state_in = ST_LINK;
               end
            end
         end
         ST_LINK:    state_in = ST_WR2;
         ST_WR2:     state_in = ST_IDLE;
         ST_CLR_RD:  state_in = ST_CLR_WR;
         ST_CLR_WR: begin
            state_in = (count_ff != CNT_W'(1) && rn.v) ? ST_CLR_RD : ST_CLR_FIX;
         end
         ST_CLR_FIX: state_in = ST_IDLE;
         default:    state_in = ST_IDLE;
      endcase
   end

   // Read addresses: the neighbor link each action needs first
   always_comb begin
      if (state_ff == ST_CLR_RD) begin
         next_raddr = head_ff.idx;
      end else if (cmd.op == OP_POP_HEAD || cmd.op == OP_CLEAR) begin
         next_raddr = head_ff.idx;
      end else if (cmd.op == OP_INSERT) begin
         next_raddr = cmd.after;
      end else begin
         next_raddr = cmd.cell_idx;
      end
      prev_raddr = (cmd.op == OP_POP_TAIL) ? tail_ff.idx : cmd.cell_idx;
   end

   // Datapath: pointer updates, link writes, result word
   always_comb begin
      cmd_pop   = 1'b0;
      cmd_in    = cmd_ff;
      head_in   = head_ff;
      tail_in   = tail_ff;
      count_in  = count_ff;
      res_in    = res_ff;
      rp_in     = rp_ff;
      rn_in     = rn_ff;
      status_in = status_ff;
      popped_in = popped_ff;
      wr2_in    = wr2_ff;
      rsp_in    = rsp_ff;
      strobe_in = 1'b0;
      wr        = '0;

      unique case (state_ff)
         ST_IDLE: begin
            cmd_pop   = cmd_valid;
            cmd_in    = cmd;
            popped_in = 1'b0;
         end

         ST_LINK: begin
            status_in = 1'b0;
            res_in    = LINK_NONE;
            rp_in     = LINK_NONE;
            rn_in     = LINK_NONE;
            wr2_in    = '0;
            unique case (cmd_ff.op)
               OP_POP_HEAD: begin
                  if (!head_ff.v) begin
                     status_in = 1'b1;
                  end else begin
                     res_in  = head_ff;
                     head_in = rn;
                     if (!rn.v) begin
                        tail_in = LINK_NONE;
                     end else begin
                        wr.prev_en   = 1'b1;
                        wr.prev_addr = rn.idx;
                        wr.prev_data = LINK_NONE;
                     end
                     count_in          = count_ff - 1'b1;
                     wr2_in.next_en    = 1'b1;
                     wr2_in.next_addr  = head_ff.idx;
                     wr2_in.next_data  = LINK_NONE;
                     wr2_in.prev_en    = 1'b1;
                     wr2_in.prev_addr  = head_ff.idx;
                     wr2_in.prev_data  = LINK_NONE;
                  end
               end

               OP_POP_TAIL: begin
                  if (!tail_ff.v) begin
                     status_in = 1'b1;
                  end else begin
                     res_in  = tail_ff;
                     tail_in = rp;
                     if (!rp.v) begin
                        head_in = LINK_NONE;
                     end else begin
                        wr.next_en   = 1'b1;
                        wr.next_addr = rp.idx;
                        wr.next_data = LINK_NONE;
                     end
                     count_in          = count_ff - 1'b1;
                     wr2_in.next_en    = 1'b1;
                     wr2_in.next_addr  = tail_ff.idx;
                     wr2_in.next_data  = LINK_NONE;
                     wr2_in.prev_en    = 1'b1;
                     wr2_in.prev_addr  = tail_ff.idx;
                     wr2_in.prev_data  = LINK_NONE;
                  end
               end

               OP_UNLINK: begin
                  if (!head_ff.v) begin
                     status_in = 1'b1;
                  end else begin
                     res_in = mk_link(cmd_ff.cell_idx);
                     // splice neighbors as they stand, membership unchecked
                     if (rp.v) begin
                        wr.next_en   = 1'b1;
                        wr.next_addr = rp.idx;
                        wr.next_data = rn;
                     end else begin
                        head_in = rn;
                     end
                     if (rn.v) begin
                        wr.prev_en   = 1'b1;
                        wr.prev_addr = rn.idx;
                        wr.prev_data = rp;
                     end else begin
                        tail_in = rp;
                     end
                     count_in          = count_ff - 1'b1;
                     wr2_in.next_en    = 1'b1;
                     wr2_in.next_addr  = cmd_ff.cell_idx;
                     wr2_in.next_data  = LINK_NONE;
                     wr2_in.prev_en    = 1'b1;
                     wr2_in.prev_addr  = cmd_ff.cell_idx;
                     wr2_in.prev_data  = LINK_NONE;
                  end
               end

               OP_PUSH_HEAD: begin
                  res_in       = mk_link(cmd_ff.cell_idx);
                  wr.prev_en   = 1'b1;
                  wr.prev_addr = cmd_ff.cell_idx;
                  wr.prev_data = LINK_NONE;
                  wr.next_en   = 1'b1;
                  wr.next_addr = cmd_ff.cell_idx;
                  head_in      = mk_link(cmd_ff.cell_idx);
                  if (!head_ff.v) begin
                     wr.next_data = LINK_NONE;
                     tail_in      = mk_link(cmd_ff.cell_idx);
                     count_in     = CNT_W'(1);
                  end else begin
                     wr.next_data     = head_ff;
                     wr2_in.prev_en   = 1'b1;
                     wr2_in.prev_addr = head_ff.idx;
                     wr2_in.prev_data = mk_link(cmd_ff.cell_idx);
                     count_in         = count_ff + 1'b1;
                  end
               end

               OP_PUSH_TAIL: begin
                  res_in       = mk_link(cmd_ff.cell_idx);
                  wr.prev_en   = 1'b1;
                  wr.prev_addr = cmd_ff.cell_idx;
                  wr.next_en   = 1'b1;
                  wr.next_addr = cmd_ff.cell_idx;
                  wr.next_data = LINK_NONE;
                  tail_in      = mk_link(cmd_ff.cell_idx);
                  // a head without a tail counts as empty
                  if (!head_ff.v || !tail_ff.v) begin
                     wr.prev_data = LINK_NONE;
                     head_in      = mk_link(cmd_ff.cell_idx);
                     count_in     = CNT_W'(1);
                  end else begin
                     wr.prev_data     = tail_ff;
                     wr2_in.next_en   = 1'b1;
                     wr2_in.next_addr = tail_ff.idx;
                     wr2_in.next_data = mk_link(cmd_ff.cell_idx);
                     count_in         = count_ff + 1'b1;
                  end
               end

               OP_INSERT: begin
                  if (!head_ff.v) begin
                     status_in = 1'b1;
                  end else begin
                     res_in       = mk_link(cmd_ff.cell_idx);
                     wr.next_en   = 1'b1;
                     wr.next_addr = cmd_ff.after;
                     wr.next_data = mk_link(cmd_ff.cell_idx);
                     if (rn.v) begin
                        wr.prev_en   = 1'b1;
                        wr.prev_addr = rn.idx;
                        wr.prev_data = mk_link(cmd_ff.cell_idx);
                     end else begin
                        tail_in = mk_link(cmd_ff.cell_idx);
                     end
                     count_in          = count_ff + 1'b1;
                     wr2_in.prev_en    = 1'b1;
                     wr2_in.prev_addr  = cmd_ff.cell_idx;
                     wr2_in.prev_data  = mk_link(cmd_ff.after);
                     wr2_in.next_en    = 1'b1;
                     wr2_in.next_addr  = cmd_ff.cell_idx;
                     wr2_in.next_data  = rn;
                  end
               end

               OP_READ: begin
                  res_in = mk_link(cmd_ff.cell_idx);
                  rp_in  = rp;
                  rn_in  = rn;
               end

               OP_NOP, OP_CLEAR: begin
               end

               default: begin
               end
            endcase
         end

         ST_WR2: begin
            wr        = wr2_ff;
            rsp_in    = make_rsp(status_ff, res_ff, rp_ff, rn_ff, head_ff, tail_ff,
                                 count_ff);
            strobe_in = 1'b1;
         end

         ST_CLR_RD: begin
         end

         // One head pop per pass; the new head's back link is fixed at the end
         ST_CLR_WR: begin
            wr.next_en   = 1'b1;
            wr.next_addr = head_ff.idx;
            wr.next_data = LINK_NONE;
            wr.prev_en   = 1'b1;
            wr.prev_addr = head_ff.idx;
            wr.prev_data = LINK_NONE;
            head_in      = rn;
            if (!rn.v) begin
               tail_in = LINK_NONE;
            end
            count_in  = count_ff - 1'b1;
            popped_in = 1'b1;
         end

         ST_CLR_FIX: begin
            if (popped_ff && head_ff.v) begin
               wr.prev_en   = 1'b1;
               wr.prev_addr = head_ff.idx;
               wr.prev_data = LINK_NONE;
            end
            rsp_in    = make_rsp(1'b0, LINK_NONE, LINK_NONE, LINK_NONE, head_ff, tail_ff,
                                 count_ff);
            strobe_in = 1'b1;
         end

         default: begin
         end
      endcase
   end

   // Payload registers
   always_ff @(posedge clock) begin
      cmd_ff    <= cmd_in;
      res_ff    <= res_in;
      rp_ff     <= rp_in;
      rn_ff     <= rn_in;
      status_ff <= status_in;
      popped_ff <= popped_in;
      wr2_ff    <= wr2_in;
      rsp_ff    <= rsp_in;
   end

   // Control and list pointers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         head_ff   <= mk_link('0);
         tail_ff   <= mk_link(LAST_CELL);
         count_ff  <= CELL_LIMIT;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         head_ff   <= head_in;
         tail_ff   <= tail_in;
         count_ff  <= count_in;
         strobe_ff <= strobe_in;
      end
   end

   assign rsp        = rsp_ff;
   assign rsp_strobe = strobe_ff;

endmodule

// ===== rtl/indexed_doubly_linked_list.sv =====
`timescale 1ns / 1ps

// Doubly linked list over a pool of 256 numbered cells, with head, tail and
// count. Issue a word with start while busy is low; a two-entry queue takes
// words while the list engine works. Each word yields exactly one result,
// shown for a single cycle with rsp_strobe; there is no way to hold it off,
// so capture it on that cycle. Every action except clear goes through three
// engine steps in order (read the neighbor link, first link writes, second
// link writes), as each link memory has a single write port. Clear pops
// every cell off the head in turn, then reports. After reset all cells are
// chained in index order and the block takes words at once.
module indexed_doubly_linked_list
   import lddl_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  logic [2:0]       req_action,
   input  logic [IDX_W-1:0] req_cell_req,
   input  logic [IDX_W-1:0] req_after_cell,
   output logic             rsp_strobe,
   output logic             rsp_status,
   output logic             rsp_cell_valid,
   output logic [IDX_W-1:0] rsp_result_cell,
   output logic             rsp_prev_valid,
   output logic [IDX_W-1:0] rsp_prev_index,
   output logic             rsp_next_valid,
   output logic [IDX_W-1:0] rsp_next_index,
   output logic             rsp_head_valid,
   output logic [IDX_W-1:0] rsp_head_index,
   output logic             rsp_tail_valid,
   output logic [IDX_W-1:0] rsp_tail_index,
   output logic [CNT_W-1:0] rsp_count
);

   cmd_type cmd;
   logic    cmd_valid;
   logic    cmd_pop;
   rsp_type rsp;

   lddl_front u_front (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_action     (req_action),
      .req_cell_req   (req_cell_req),
      .req_after_cell (req_after_cell),
      .cmd            (cmd),
      .cmd_valid      (cmd_valid),
      .cmd_pop        (cmd_pop)
   );

   lddl_engine u_engine (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .cmd_valid  (cmd_valid),
      .cmd_pop    (cmd_pop),
      .rsp        (rsp),
      .rsp_strobe (rsp_strobe)
   );

   // Break the result word out onto ports
   assign rsp_status      = rsp.status;
   assign rsp_cell_valid  = rsp.cell_valid;
   assign rsp_result_cell = rsp.result_cell;
   assign rsp_prev_valid  = rsp.prev_valid;
   assign rsp_prev_index  = rsp.prev_index;
   assign rsp_next_valid  = rsp.next_valid;
   assign rsp_next_index  = rsp.next_index;
   assign rsp_head_valid  = rsp.head_valid;
   assign rsp_head_index  = rsp.head_index;
   assign rsp_tail_valid  = rsp.tail_valid;
   assign rsp_tail_index  = rsp.tail_index;
   assign rsp_count       = rsp.count;

   // The engine returns to idle between results, so results never come back to back
   a_strobe_spaced: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("result strobe in two consecutive cycles");

   // An action refused on an empty list names no cell
   a_empty_no_cell: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_status) |-> !rsp_cell_valid)
      else $error("empty status reported together with a cell");

   // A missing tail reads as index zero
   a_tail_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_tail_valid) |-> (rsp_tail_index == '0))
      else $error("tail index not zero while tail is absent");

endmodule
